/* design/i8aq_pkg.sv */
package i8aq_pkg;

   localparam int MAX_LEN   = 64;
   localparam int SAMPLE_AW = $clog2(MAX_LEN);
   localparam int CNT_W     = SAMPLE_AW + 1;
   localparam int SAMPLE_W  = 16;
   localparam int HIST_BINS = 1024;
   localparam int HIST_AW   = $clog2(HIST_BINS);
   localparam int BIN_CNT_W = 7;
   localparam int RANGE_W   = SAMPLE_W + 1;
   localparam int BOUND_W   = SAMPLE_W + HIST_AW + 2;
   localparam int SCALE_W   = 24;
   localparam int CLAMP_W   = 10;
   localparam int DIV_W     = 37;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [CLAMP_W-1:0] CLAMP_FULL = CLAMP_W'(1000);
   localparam logic [7:0]         SYM_K      = 8'd127;
   localparam logic [7:0]         ASYM_K     = 8'd255;

   typedef enum logic {
      CSR_SYMMETRIC = 1'b0,
      CSR_CLAMP     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

/* design/i8aq_if.sv */
interface i8aq_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface i8aq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [7:0]  qvalue;
   logic [23:0]        scale_out;
   logic signed [7:0]  zero_point;
   logic               last_result;

   modport source (output valid, qvalue, scale_out, zero_point, last_result, input ready);
   modport sink   (input valid, qvalue, scale_out, zero_point, last_result, output ready);
endinterface

/* design/i8aq_div.sv */
module i8aq_div (
   input  logic                  clock,
   input  logic                  reset,
   input  i8aq_pkg::div_req_type div_req,
   output i8aq_pkg::div_rsp_type div_rsp
);

   logic [i8aq_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [i8aq_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [i8aq_pkg::DIV_W-1:0]     den_ff, den_in;
   logic [i8aq_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [i8aq_pkg::DIV_W:0]       trial;
   logic                           fits;

   assign trial = {rem_ff, quo_ff[i8aq_pkg::DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in = fits ? i8aq_pkg::DIV_W'(trial - {1'b0, den_ff})
                       : i8aq_pkg::DIV_W'(trial);
         quo_in = {quo_ff[i8aq_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == i8aq_pkg::DIV_CNT_W'(i8aq_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

/* design/int8_activation_quantizer.sv */
// channel   dir  handshake            payload
// req       in   valid/ready          sample (Q7.8), last_sample
// rsp       out  valid/ready          qvalue, scale_out, zero_point, last_result
// csr       in   csr_we, no wait      csr_index, csr_wdata
//
// Samples are taken one per cycle until the last one (or the 64th) arrives.
// Then the block stalls req while one shared 37-step divider does all the math:
// histogram pass when used, scale, zero point (asymmetric mode only), and one
// division per emitted result.
// After reset all 1024 histogram bins are cleared before req is ready.
// A result waits in the output register as long as rsp_ready is low.
module int8_activation_quantizer (
   input  logic              clock,
   input  logic              reset,
   i8aq_req_if.sink          req,
   i8aq_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [9:0]        csr_wdata
);

   typedef enum logic [21:0] {
      S_CLEAR    = 22'h000001,
      S_IDLE     = 22'h000002,
      S_PREP     = 22'h000004,
      S_LOWT     = 22'h000008,
      S_HIGHT    = 22'h000010,
      S_BIN_RD   = 22'h000020,
      S_BIN_ST   = 22'h000040,
      S_BIN_DIV  = 22'h000080,
      S_BIN_HRD  = 22'h000100,
      S_BIN_WR   = 22'h000200,
      S_SCAN     = 22'h000400,
      S_SCAN_END = 22'h000800,
      S_BOUND_LO = 22'h001000,
      S_BOUND_HI = 22'h002000,
      S_SCALE_ST = 22'h004000,
      S_SCALE    = 22'h008000,
      S_ZP_ST    = 22'h010000,
      S_ZP       = 22'h020000,
      S_EMIT_RD  = 22'h040000,
      S_EMIT_ST  = 22'h080000,
      S_EMIT_DIV = 22'h100000,
      S_EMIT_OUT = 22'h200000
   } state_type;

   localparam int AW  = i8aq_pkg::SAMPLE_AW;
   localparam int CW  = i8aq_pkg::CNT_W;
   localparam int HW  = i8aq_pkg::HIST_AW;
   localparam int BW  = i8aq_pkg::BOUND_W;
   localparam int DW  = i8aq_pkg::DIV_W;
   localparam int RW  = i8aq_pkg::RANGE_W;
   localparam int KW  = i8aq_pkg::BIN_CNT_W;
   localparam int SW  = i8aq_pkg::SCALE_W;

   state_type                    state_ff, state_in;
   logic                         sym_ff, sym_in;
   logic [i8aq_pkg::CLAMP_W-1:0] clamp_ff, clamp_in;
   logic [AW-1:0]                fill_ff, fill_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic signed [15:0]           mn_ff, mn_in, mx_ff, mx_in;
   logic [RW-1:0]                range_ff, range_in;
   logic                         hist_ff, hist_in;
   logic [HW-1:0]                cnt_ff, cnt_in;
   logic                         scan_vld_ff, scan_vld_in;
   logic [HW-1:0]                scan_bin_ff, scan_bin_in;
   logic [KW-1:0]                cum_ff, cum_in;
   logic [KW-1:0]                low_t_ff, low_t_in, high_t_ff, high_t_in;
   logic                         low_found_ff, low_found_in, high_found_ff, high_found_in;
   logic [HW-1:0]                low_bin_ff, low_bin_in, high_bin_ff, high_bin_in;
   logic [HW-1:0]                bin_ff, bin_in;
   logic signed [BW-1:0]         blo_ff, blo_in, bhi_ff, bhi_in;
   logic [SW-1:0]                s_ff, s_in;
   logic signed [7:0]            zp_ff, zp_in;
   logic                         neg_ff, neg_in;
   logic signed [7:0]            qv_ff, qv_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] smem [i8aq_pkg::MAX_LEN];
   logic signed [15:0] smem_rd_ff;
   logic [KW-1:0]      hist_mem [i8aq_pkg::HIST_BINS];
   logic [KW-1:0]      hist_rd_ff;
   logic               hist_we;
   logic [HW-1:0]      hist_waddr, hist_raddr;
   logic [KW-1:0]      hist_wdata;

   i8aq_pkg::div_req_type div_req;
   i8aq_pkg::div_rsp_type div_rsp;

   logic               req_acc;
   logic               vec_end;
   logic               hist_use;
   logic [16:0]        lt_num, ht_num;
   logic [RW-1:0]      diff_v;
   logic [RW+HW-1:0]   bin_num;
   logic [HW-1:0]      bin_q;
   logic [KW-1:0]      cum_nx;
   logic [HW:0]        mul_a;
   logic [BW-1:0]      prod;
   logic signed [BW-1:0] bound_nx;
   logic [BW-1:0]      abs_lo, abs_hi, mag;
   logic signed [BW-1:0] span;
   logic [7:0]         kk;
   logic [HW+7:0]      dk;
   logic [DW-1:0]      s_ext, ds;
   logic [8:0]         qz_mag;
   logic signed [10:0] zs, z2;
   logic signed [7:0]  zp_c;
   logic [15:0]        abs_x;
   logic [9:0]         qm;
   logic signed [11:0] qs, qa;
   logic signed [7:0]  q_out;
   logic [SW-1:0]      s_c;
   logic [DW-1:0]      quot;

   i8aq_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign quot      = div_rsp.quot;
   assign req.ready = (state_ff == S_IDLE);
   assign req_acc   = req.valid && req.ready;
   assign vec_end   = req.last_sample || (fill_ff == AW'(i8aq_pkg::MAX_LEN - 1));
   assign hist_use  = (clamp_ff < i8aq_pkg::CLAMP_FULL) && (n_ff > CW'(10)) && (mx_ff > mn_ff);

   assign lt_num = 17'(i8aq_pkg::CLAMP_FULL - clamp_ff) * 17'(n_ff);
   assign ht_num = 17'({1'b0, i8aq_pkg::CLAMP_FULL} + {1'b0, clamp_ff}) * 17'(n_ff);

   assign diff_v  = {smem_rd_ff[15], smem_rd_ff} - {mn_ff[15], mn_ff};
   assign bin_num = {diff_v, {HW{1'b0}}} - (RW+HW)'(diff_v);
   assign bin_q   = (|quot[DW-1:HW]) ? {HW{1'b1}} : quot[HW-1:0];
   assign cum_nx  = cum_ff + hist_rd_ff;

   assign mul_a    = (state_ff == S_BOUND_HI) ? ({1'b0, high_bin_ff} + 1'b1)
                                              : {1'b0, low_bin_ff};
   assign prod     = BW'(mul_a) * BW'(range_ff);
   assign bound_nx = (BW'(mn_ff) <<< HW) + signed'(prod);

   assign abs_lo = blo_ff[BW-1] ? BW'(-blo_ff) : BW'(blo_ff);
   assign abs_hi = bhi_ff[BW-1] ? BW'(-bhi_ff) : BW'(bhi_ff);
   assign span   = bhi_ff - blo_ff;
   assign mag    = sym_ff ? ((abs_lo > abs_hi) ? abs_lo : abs_hi)
                          : (span[BW-1] ? '0 : BW'(span));
   assign kk     = sym_ff ? i8aq_pkg::SYM_K : i8aq_pkg::ASYM_K;
   assign dk     = hist_ff ? {kk, {HW{1'b0}}} : (HW+8)'(kk);

   assign s_c   = (quot == '0) ? SW'(1) : ((|quot[DW-1:SW]) ? {SW{1'b1}} : quot[SW-1:0]);
   assign s_ext = DW'(s_ff);
   assign ds    = hist_ff ? (s_ext << HW) : s_ext;

   assign qz_mag = (|quot[DW-1:9]) ? 9'd511 : quot[8:0];
   assign zs     = neg_ff ? -signed'({2'b00, qz_mag}) : signed'({2'b00, qz_mag});
   assign z2     = zs - 11'sd128;
   assign zp_c   = (z2 > 11'sd127) ? 8'sd127 : ((z2 < -11'sd128) ? -8'sd128 : 8'(z2));

   assign abs_x = smem_rd_ff[15] ? 16'(-smem_rd_ff) : 16'(smem_rd_ff);
   assign qm    = (quot > DW'(1000)) ? 10'd1000 : quot[9:0];
   assign qs    = neg_ff ? -signed'({2'b00, qm}) : signed'({2'b00, qm});
   assign qa    = qs + 12'(zp_ff);

   always_comb begin
      if (sym_ff) begin
         q_out = (qs > 12'sd127) ? 8'sd127 : ((qs < -12'sd127) ? -8'sd127 : 8'(qs));
      end else begin
         q_out = (qa > 12'sd127) ? 8'sd127 : ((qa < -12'sd128) ? -8'sd128 : 8'(qa));
      end
   end

   // histogram memory port control
   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = cnt_ff;
      hist_wdata = '0;
      hist_raddr = cnt_ff;
      case (state_ff)
         S_CLEAR: hist_we = 1'b1;
         S_SCAN:  hist_we = 1'b1;
         S_BIN_HRD: hist_raddr = bin_ff;
         S_BIN_WR: begin
            hist_we    = 1'b1;
            hist_waddr = bin_ff;
            hist_wdata = hist_rd_ff + 1'b1;
         end
         default: hist_we = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      clamp_in      = clamp_ff;
      fill_in       = fill_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      mn_in         = mn_ff;
      mx_in         = mx_ff;
      range_in      = range_ff;
      hist_in       = hist_ff;
      cnt_in        = cnt_ff;
      scan_vld_in   = (state_ff == S_SCAN);
      scan_bin_in   = cnt_ff;
      cum_in        = cum_ff;
      low_t_in      = low_t_ff;
      high_t_in     = high_t_ff;
      low_found_in  = low_found_ff;
      high_found_in = high_found_ff;
      low_bin_in    = low_bin_ff;
      high_bin_in   = high_bin_ff;
      bin_in        = bin_ff;
      blo_in        = blo_ff;
      bhi_in        = bhi_ff;
      s_in          = s_ff;
      zp_in         = zp_ff;
      neg_in        = neg_ff;
      qv_in         = qv_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff;
      div_req       = '0;

      if (csr_we) begin
         case (csr_index)
            i8aq_pkg::CSR_SYMMETRIC: sym_in   = csr_wdata[0];
            i8aq_pkg::CSR_CLAMP:     clamp_in = csr_wdata;
            default:                 sym_in   = sym_ff;
         endcase
      end

      // cumulative scan of bins returned from memory
      if (scan_vld_ff) begin
         cum_in = cum_nx;
         if (!low_found_ff && cum_nx >= low_t_ff) begin
            low_found_in = 1'b1;
            low_bin_in   = scan_bin_ff;
         end
         if (!high_found_ff && cum_nx >= high_t_ff) begin
            high_found_in = 1'b1;
            high_bin_in   = scan_bin_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {HW{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc) begin
               if (fill_ff == '0 || req.sample < mn_ff) mn_in = req.sample;
               if (fill_ff == '0 || req.sample > mx_ff) mx_in = req.sample;
               if (vec_end) begin
                  n_in     = CW'(fill_ff) + 1'b1;
                  fill_in  = '0;
                  state_in = S_PREP;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         S_PREP: begin
            hist_in       = hist_use;
            range_in      = {mx_ff[15], mx_ff} - {mn_ff[15], mn_ff};
            cum_in        = '0;
            low_found_in  = 1'b0;
            high_found_in = 1'b0;
            low_bin_in    = '0;
            high_bin_in   = {HW{1'b1}};
            if (hist_use) begin
               div_req.start = 1'b1;
               div_req.num   = DW'(lt_num);
               div_req.den   = DW'(2000);
               state_in      = S_LOWT;
            end else begin
               blo_in   = BW'(mn_ff);
               bhi_in   = BW'(mx_ff);
               state_in = S_SCALE_ST;
            end
         end
         S_LOWT: begin
            if (div_rsp.done) begin
               low_t_in      = KW'(quot);
               div_req.start = 1'b1;
               div_req.num   = DW'(ht_num);
               div_req.den   = DW'(2000);
               state_in      = S_HIGHT;
            end
         end
         S_HIGHT: begin
            if (div_rsp.done) begin
               high_t_in = KW'(quot);
               idx_in    = '0;
               state_in  = S_BIN_RD;
            end
         end
         S_BIN_RD: state_in = S_BIN_ST;
         S_BIN_ST: begin
            div_req.start = 1'b1;
            div_req.num   = DW'(bin_num);
            div_req.den   = DW'(range_ff);
            state_in      = S_BIN_DIV;
         end
         S_BIN_DIV: begin
            if (div_rsp.done) begin
               bin_in   = bin_q;
               state_in = S_BIN_HRD;
            end
         end
         S_BIN_HRD: state_in = S_BIN_WR;
         S_BIN_WR: begin
            if (CW'(idx_ff) == n_ff - 1'b1) begin
               cnt_in   = '0;
               state_in = S_SCAN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_BIN_RD;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == {HW{1'b1}}) state_in = S_SCAN_END;
         end
         S_SCAN_END: state_in = S_BOUND_LO;
         S_BOUND_LO: begin
            blo_in   = bound_nx;
            state_in = S_BOUND_HI;
         end
         S_BOUND_HI: begin
            bhi_in   = bound_nx;
            state_in = S_SCALE_ST;
         end
         S_SCALE_ST: begin
            div_req.start = 1'b1;
            div_req.num   = (DW'(mag) << 9) + DW'(dk);
            div_req.den   = DW'(dk) << 1;
            state_in      = S_SCALE;
         end
         S_SCALE: begin
            if (div_rsp.done) begin
               s_in   = s_c;
               idx_in = '0;
               if (sym_ff) begin
                  zp_in    = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  state_in = S_ZP_ST;
               end
            end
         end
         S_ZP_ST: begin
            div_req.start = 1'b1;
            div_req.num   = (DW'(abs_lo) << 9) + ds;
            div_req.den   = ds << 1;
            neg_in        = (blo_ff > 0);
            state_in      = S_ZP;
         end
         S_ZP: begin
            if (div_rsp.done) begin
               zp_in    = zp_c;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: state_in = S_EMIT_ST;
         S_EMIT_ST: begin
            div_req.start = 1'b1;
            div_req.num   = (DW'(abs_x) << 9) + s_ext;
            div_req.den   = s_ext << 1;
            neg_in        = smem_rd_ff[15];
            state_in      = S_EMIT_DIV;
         end
         S_EMIT_DIV: begin
            if (div_rsp.done) begin
               qv_in        = q_out;
               last_in      = (CW'(idx_ff) == n_ff - 1'b1);
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT_OUT;
            end
         end
         S_EMIT_OUT: begin
            // hold until the result is taken
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc) smem[fill_ff] <= req.sample;
      smem_rd_ff <= smem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      range_ff     <= range_in;
      scan_bin_ff  <= scan_bin_in;
      low_t_ff     <= low_t_in;
      high_t_ff    <= high_t_in;
      low_bin_ff   <= low_bin_in;
      high_bin_ff  <= high_bin_in;
      bin_ff       <= bin_in;
      blo_ff       <= blo_in;
      bhi_ff       <= bhi_in;
      s_ff         <= s_in;
      zp_ff        <= zp_in;
      neg_ff       <= neg_in;
      qv_ff        <= qv_in;
      last_ff      <= last_in;
      cum_ff       <= cum_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      hist_ff      <= hist_in;
      if (reset) begin
         state_ff      <= S_CLEAR;
         sym_ff        <= 1'b1;
         clamp_ff      <= i8aq_pkg::CLAMP_FULL;
         fill_ff       <= '0;
         mn_ff         <= '0;
         mx_ff         <= '0;
         cnt_ff        <= '0;
         scan_vld_ff   <= 1'b0;
         low_found_ff  <= 1'b0;
         high_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sym_ff        <= sym_in;
         clamp_ff      <= clamp_in;
         fill_ff       <= fill_in;
         mn_ff         <= mn_in;
         mx_ff         <= mx_in;
         cnt_ff        <= cnt_in;
         scan_vld_ff   <= scan_vld_in;
         low_found_ff  <= low_found_in;
         high_found_ff <= high_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.qvalue      = qv_ff;
   assign rsp.scale_out   = s_ff;
   assign rsp.zero_point  = zp_ff;
   assign rsp.last_result = last_ff;

endmodule
